/* rtl/core/pivfc_pkg.sv */
// PI valve flow controller: shared types and constants.
// Holds register index codes and the reciprocal constants for the fixed
// divisions; no dependencies.
package pivfc_pkg;

	// Configuration register indexes
	typedef enum logic [2:0] {
		REG_PROP_GAIN      = 3'd0,
		REG_INTEG_GAIN     = 3'd1,
		REG_INTEGRAL_UPPER = 3'd2,
		REG_INTEGRAL_LOWER = 3'd3,
		REG_VALVE_OFF_CODE = 3'd4,
		REG_ADJUST_MINIMUM = 3'd5
	} cfg_reg_t;

	localparam int CfgIndexW = 3;
	localparam int CfgDataW  = 21;

	// Register reset values
	localparam logic [19:0] UpperReset   = 20'd40000;
	localparam logic [15:0] LimitReset   = 16'd4000;
	localparam logic [15:0] OffCodeReset = 16'hFFFF;
	localparam logic [15:0] CmdCeil      = 16'hFFFF;

	// x / 1000 = (x >> 3) / 125; 29-bit dividend, exact with shift 36
	localparam logic [29:0] Recip125 = 30'd549755814;
	localparam int          Shift125 = 36;
	// 23-bit dividend / 10, exact with shift 27
	localparam logic [23:0] Recip10  = 24'd13421773;
	localparam int          Shift10  = 27;
	// 20-bit dividend / 10, exact with shift 24
	localparam logic [20:0] Recip10U = 21'd1677722;
	localparam int          Shift10U = 24;

endpackage

/* rtl/core/pi_valve_flow_controller_top.sv */
// PI valve flow controller, top level: eight-stage pipeline with clamped
// integral accumulator and config register file.
// Depends on pivfc_pkg.
//
// Usage:
//   Input words arrive on s_axis (one control tick each); result words leave
//   on m_axis. Config registers are written over cfg_valid/cfg_index/cfg_data,
//   which is always ready; write them only while no tick is in flight.
//   Each word passes through eight register stages before its result word is
//   presented on m_axis.
//   Throughput: one word per cycle while m_axis_tready is high. Each stage
//   holds at most one word and moves on whenever the stage after it is empty
//   or moving, so the single accumulator update stage sets that rate.
//   When the receiver stalls, words pile up in empty stages; s_axis_tready
//   falls only once all eight stages are full.
//   Reset clears all stage valids and the accumulator and loads defaults
//   (upper clamp 40000, off code 65535, command limit 4000, others zero).
module pi_valve_flow_controller_top
	import pivfc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// Input stream
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	// [15:0] flow_target, [31:16] flow_measured, [47:32] adjust_setting,
	// [48] full_oxygen_on, [49] maintenance_on, [55:50] zero
	input  logic [55:0]          s_axis_tdata,
	// Result stream
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// [15:0] valve_drive, [31:16] valve_command
	output logic [31:0]          m_axis_tdata,
	// Configuration write channel
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CfgIndexW-1:0] cfg_index,
	input  logic [CfgDataW-1:0]  cfg_data
);

	// Config registers
	logic        [15:0] prop_gain_q;
	logic        [15:0] integ_gain_q;
	logic        [19:0] integral_upper_q;
	logic signed [20:0] integral_lower_q;
	logic        [15:0] valve_off_code_q;
	logic        [15:0] adjust_minimum_q;
	logic        [15:0] cmd_limit_q;

	// Integrator state
	logic signed [20:0] acc_q;

	// Stage valids and advance
	logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, v8_q;
	logic adv1, adv2, adv3, adv4, adv5, adv6, adv7, adv8;

	// Stage payloads
	logic signed [15:0] target_s1, measured_s1;
	logic        [15:0] adjust_s1;
	logic               full_o2_s1, maint_s1;
	logic signed [33:0] pprod_s2, iprod_s2;
	logic               en_s2;
	logic        [58:0] pmul_s3, imul_s3;
	logic               pneg_s3, ineg_s3, en_s3;
	logic signed [23:0] prop_s4, inc_s4;
	logic               en_s4;
	logic signed [23:0] prop_s5;
	logic               en_s5;
	logic signed [24:0] sum_s6;
	logic               en_s6;
	logic        [46:0] dmul_s7;
	logic               en_s7;
	logic        [15:0] drive_s8, cmd_s8;

	// Combinational intermediates
	logic signed [16:0] err_c;
	logic        [33:0] pabs_c, iabs_c;
	logic        [22:0] pquo_c, iquo_c;
	logic signed [24:0] acc_sum_c, upper_ext_c, lower_ext_c, acc_hi_c, acc_new_c;
	logic        [22:0] sum_mag_c;
	logic        [19:0] cmd_raw_c;
	logic        [15:0] cmd_c, drive_c;
	logic        [40:0] limit_mul_c;
	logic        [16:0] limit_raw_c;

	// Per-stage advance: a stage moves when it is empty or the next moves
	assign adv8 = !v8_q || m_axis_tready;
	assign adv7 = !v7_q || adv8;
	assign adv6 = !v6_q || adv7;
	assign adv5 = !v5_q || adv6;
	assign adv4 = !v4_q || adv5;
	assign adv3 = !v3_q || adv4;
	assign adv2 = !v2_q || adv3;
	assign adv1 = !v1_q || adv2;

	assign s_axis_tready = adv1;
	assign m_axis_tvalid = v8_q;
	assign m_axis_tdata  = {cmd_s8, drive_s8};
	assign cfg_ready     = 1'b1;

	// Config register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q      <= '0;
			integ_gain_q     <= '0;
			integral_upper_q <= UpperReset;
			integral_lower_q <= '0;
			valve_off_code_q <= OffCodeReset;
			adjust_minimum_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_PROP_GAIN:      prop_gain_q      <= cfg_data[15:0];
				REG_INTEG_GAIN:     integ_gain_q     <= cfg_data[15:0];
				REG_INTEGRAL_UPPER: integral_upper_q <= cfg_data[19:0];
				REG_INTEGRAL_LOWER: integral_lower_q <= $signed(cfg_data[20:0]);
				REG_VALVE_OFF_CODE: valve_off_code_q <= cfg_data[15:0];
				REG_ADJUST_MINIMUM: adjust_minimum_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// Command limit: upper clamp / 10, saturated to 16 bits
	assign limit_mul_c = 41'(integral_upper_q) * 41'(Recip10U);
	assign limit_raw_c = limit_mul_c[Shift10U +: 17];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_limit_q <= LimitReset;
		end else begin
			cmd_limit_q <= (limit_raw_c > 17'(CmdCeil)) ? CmdCeil : limit_raw_c[15:0];
		end
	end

	// Stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
			v4_q <= 1'b0;
			v5_q <= 1'b0;
			v6_q <= 1'b0;
			v7_q <= 1'b0;
			v8_q <= 1'b0;
		end else begin
			if (adv1) v1_q <= s_axis_tvalid;
			if (adv2) v2_q <= v1_q;
			if (adv3) v3_q <= v2_q;
			if (adv4) v4_q <= v3_q;
			if (adv5) v5_q <= v4_q;
			if (adv6) v6_q <= v5_q;
			if (adv7) v7_q <= v6_q;
			if (adv8) v8_q <= v7_q;
		end
	end

	// Stage 1: capture input word
	always_ff @(posedge clk) begin
		if (adv1) begin
			target_s1   <= $signed(s_axis_tdata[15:0]);
			measured_s1 <= $signed(s_axis_tdata[31:16]);
			adjust_s1   <= s_axis_tdata[47:32];
			full_o2_s1  <= s_axis_tdata[48];
			maint_s1    <= s_axis_tdata[49];
		end
	end

	// Stage 2: error and gain products, valve enable
	assign err_c = 17'(target_s1) - 17'(measured_s1);

	always_ff @(posedge clk) begin
		if (adv2) begin
			pprod_s2 <= $signed({1'b0, prop_gain_q}) * err_c;
			iprod_s2 <= $signed({1'b0, integ_gain_q}) * err_c;
			en_s2    <= (adjust_s1 > adjust_minimum_q) || full_o2_s1 || maint_s1;
		end
	end

	// Stage 3: magnitude, drop low three bits, multiply by reciprocal of 125
	assign pabs_c = pprod_s2[33] ? 34'(-pprod_s2) : 34'(pprod_s2);
	assign iabs_c = iprod_s2[33] ? 34'(-iprod_s2) : 34'(iprod_s2);

	always_ff @(posedge clk) begin
		if (adv3) begin
			pmul_s3 <= 59'(pabs_c[31:3]) * 59'(Recip125);
			imul_s3 <= 59'(iabs_c[31:3]) * 59'(Recip125);
			pneg_s3 <= pprod_s2[33];
			ineg_s3 <= iprod_s2[33];
			en_s3   <= en_s2;
		end
	end

	// Stage 4: quotients by 1000, restore sign (truncation toward zero)
	assign pquo_c = pmul_s3[Shift125 +: 23];
	assign iquo_c = imul_s3[Shift125 +: 23];

	always_ff @(posedge clk) begin
		if (adv4) begin
			prop_s4 <= pneg_s3 ? -$signed({1'b0, pquo_c}) : $signed({1'b0, pquo_c});
			inc_s4  <= ineg_s3 ? -$signed({1'b0, iquo_c}) : $signed({1'b0, iquo_c});
			en_s4   <= en_s3;
		end
	end

	// Stage 5: integrate and clamp, upper bound first then lower
	assign acc_sum_c   = 25'(acc_q) + 25'(inc_s4);
	assign upper_ext_c = $signed({5'b0, integral_upper_q});
	assign lower_ext_c = 25'(integral_lower_q);
	assign acc_hi_c    = (acc_sum_c > upper_ext_c) ? upper_ext_c : acc_sum_c;
	assign acc_new_c   = (acc_hi_c < lower_ext_c) ? lower_ext_c : acc_hi_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (v4_q && adv5) begin
			acc_q <= acc_new_c[20:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv5) begin
			prop_s5 <= prop_s4;
			en_s5   <= en_s4;
		end
	end

	// Stage 6: proportional plus integral (acc_q holds this word's value)
	always_ff @(posedge clk) begin
		if (adv6) begin
			sum_s6 <= 25'(prop_s5) + 25'(acc_q);
			en_s6  <= en_s5;
		end
	end

	// Stage 7: negative sum gives zero; multiply by reciprocal of 10
	assign sum_mag_c = sum_s6[24] ? '0 : sum_s6[22:0];

	always_ff @(posedge clk) begin
		if (adv7) begin
			dmul_s7 <= 47'(sum_mag_c) * 47'(Recip10);
			en_s7   <= en_s6;
		end
	end

	// Stage 8: clamp command, form drive code
	assign cmd_raw_c = dmul_s7[Shift10 +: 20];
	assign cmd_c     = (cmd_raw_c > 20'(cmd_limit_q)) ? cmd_limit_q : cmd_raw_c[15:0];

	always_comb begin
		drive_c = valve_off_code_q;
		if (en_s7) begin
			drive_c = (cmd_c > valve_off_code_q) ? '0 : valve_off_code_q - cmd_c;
		end
	end

	always_ff @(posedge clk) begin
		if (adv8) begin
			drive_s8 <= drive_c;
			cmd_s8   <= cmd_c;
		end
	end

`ifndef NO_ASSERTIONS
	// Command never exceeds the configured limit
	a_cmd_limit: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (cmd_s8 <= cmd_limit_q))
		else $error("valve_command above limit");

	// Drive code never exceeds the off code
	a_drive_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (drive_s8 <= valve_off_code_q))
		else $error("valve_drive above off code");

	// Accumulator changes only when a word enters the integrate stage
	a_acc_update: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(acc_q) |-> $past(v4_q && adv5))
		else $error("accumulator changed without a word");
`endif

endmodule
